/* src/kmd_pkg.sv */
// ----------------------------------------------------------------------------
// kmd_pkg
// shared constants and knight move offsets for the knight move distance block
// ----------------------------------------------------------------------------
package kmd_pkg;

  // default largest board side
  localparam int MAX_SIDE_DEF = 256;

  // column offset of knight move k
  function automatic logic signed [2:0] knight_dx(input logic [2:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd1: d = 3'sd2;
      3'd2, 3'd3: d = 3'sd1;
      3'd4, 3'd5: d = -3'sd2;
      default:    d = -3'sd1;
    endcase
    return d;
  endfunction

  // row offset of knight move k
  function automatic logic signed [2:0] knight_dy(input logic [2:0] k);
    logic signed [2:0] d;
    unique case (k)
      3'd0, 3'd4: d = 3'sd1;
      3'd1, 3'd5: d = -3'sd1;
      3'd2, 3'd6: d = 3'sd2;
      default:    d = -3'sd2;
    endcase
    return d;
  endfunction

endpackage

/* src/knight_move_distance.sv */
// ----------------------------------------------------------------------------
// knight_move_distance
// breadth-first knight move distance between two squares of a square board
// ----------------------------------------------------------------------------
// A query word is taken when start is high and busy is low. The answer
// comes back on move_count_o and reached_o for one cycle with done_o high;
// the receiver cannot stall it, so it must take the word in that cycle.
// When start and target are the same square the answer appears in the next
// cycle and busy stays low. Any other query first runs a clearing pass
// over the whole visited map, one square a cycle, then the search itself:
// a check that both squares lie on the board, then, for every square taken
// off the queue, one queue read, the eight neighbors in turn and one
// level-closing step, since each neighbor costs one visited-map read.
// The distance saturates at 255; an unreachable target, or a start or
// target off the board, answers 0 with reached_o low.
// ----------------------------------------------------------------------------
module knight_move_distance
  import kmd_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [8:0] board_side_i,
  input  logic [7:0] start_x_i,
  input  logic [7:0] start_y_i,
  input  logic [7:0] target_x_i,
  input  logic [7:0] target_y_i,
  output logic       done_o,
  output logic [7:0] move_count_o,
  output logic       reached_o
);

  // coordinate, address and compare widths
  localparam int CW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * CW;
  localparam int PW    = AW + 1;
  localparam int SideW = CW + 1;
  localparam int CmpW  = (SideW > 9) ? SideW : 9;
  localparam int DW    = (AW > 8) ? AW : 8;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLEAR = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_POP   = 3'd3;
  localparam logic [2:0] S_NB    = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [SideW-1:0] side_q, side_d;
  logic [7:0]       sx_q, sx_d, sy_q, sy_d, tx_q, tx_d, ty_q, ty_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [PW-1:0]    head_q, head_d, tail_q, tail_d, lvl_q, lvl_d;
  logic [DW-1:0]    dist_q, dist_d;
  logic [2:0]       k_q, k_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic             done_q, done_d;
  logic [7:0]       move_q, move_d;
  logic             reached_q, reached_d;

  // memory ports
  logic          vis_we, vis_wdata, vis_rdata;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic          q_we, q_re;
  logic [AW-1:0] q_waddr, q_wdata, q_raddr, q_rdata;

  // neighbor of the square at the head of the queue
  logic [CW-1:0]        cur_x, cur_y, tx_c, ty_c;
  logic signed [CW+1:0] nx, ny;
  logic                 nb_in, nb_hit;
  logic [AW-1:0]        nb_addr;
  logic                 push;
  logic [PW-1:0]        tail_nxt;
  logic [DW:0]          dist_inc;
  logic                 ends_ok;

  assign cur_x = q_rdata[CW-1:0];
  assign cur_y = q_rdata[AW-1:CW];
  assign tx_c  = CW'(tx_q);
  assign ty_c  = CW'(ty_q);

  assign nx = $signed({2'b00, cur_x}) + (CW+2)'(knight_dx(k_q));
  assign ny = $signed({2'b00, cur_y}) + (CW+2)'(knight_dy(k_q));

  assign nb_in   = !nx[CW+1] && !ny[CW+1] &&
                   (nx[CW:0] < side_q) && (ny[CW:0] < side_q);
  assign nb_hit  = nb_in && (nx[CW-1:0] == tx_c) && (ny[CW-1:0] == ty_c);
  assign nb_addr = {ny[CW-1:0], nx[CW-1:0]};

  // previous neighbor came back unvisited: mark it and queue it
  assign push     = pend_q && !vis_rdata && (state_q == S_NB || state_q == S_LAST);
  assign tail_nxt = tail_q + PW'(push);
  assign dist_inc = {1'b0, dist_q} + (DW+1)'(1);

  // both squares on the board
  assign ends_ok = (CmpW'(sx_q) < CmpW'(side_q)) && (CmpW'(sy_q) < CmpW'(side_q)) &&
                   (CmpW'(tx_q) < CmpW'(side_q)) && (CmpW'(ty_q) < CmpW'(side_q));

  always_comb begin
    state_d     = state_q;
    side_d      = side_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    tx_d        = tx_q;
    ty_d        = ty_q;
    clr_d       = clr_q;
    head_d      = head_q;
    tail_d      = tail_nxt;
    lvl_d       = lvl_q;
    dist_d      = dist_q;
    k_d         = k_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    done_d      = 1'b0;
    move_d      = move_q;
    reached_d   = reached_q;

    vis_we    = push;
    vis_waddr = pend_addr_q;
    vis_wdata = 1'b1;
    vis_raddr = nb_addr;
    q_we      = push;
    q_waddr   = tail_q[AW-1:0];
    q_wdata   = pend_addr_q;
    q_re      = 1'b0;
    q_raddr   = head_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          sx_d = start_x_i;
          sy_d = start_y_i;
          tx_d = target_x_i;
          ty_d = target_y_i;
          if (CmpW'(board_side_i) > CmpW'(MAX_SIDE)) begin
            side_d = SideW'(MAX_SIDE);
          end else begin
            side_d = SideW'(board_side_i);
          end
          if (start_x_i == target_x_i && start_y_i == target_y_i) begin
            // same square: answer at once
            done_d    = 1'b1;
            move_d    = 8'd0;
            reached_d = 1'b1;
          end else begin
            clr_d   = '0;
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_q;
        vis_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = S_INIT;
        end
      end
      S_INIT: begin
        if (!ends_ok) begin
          done_d    = 1'b1;
          move_d    = 8'd0;
          reached_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          // seed the queue with the start square
          vis_we    = 1'b1;
          vis_waddr = {CW'(sy_q), CW'(sx_q)};
          q_we      = 1'b1;
          q_waddr   = '0;
          q_wdata   = {CW'(sy_q), CW'(sx_q)};
          head_d    = '0;
          tail_d    = PW'(1);
          lvl_d     = PW'(1);
          dist_d    = '0;
          state_d   = S_POP;
        end
      end
      S_POP: begin
        if (head_q == tail_q) begin
          // frontier empty, target unreachable
          done_d    = 1'b1;
          move_d    = 8'd0;
          reached_d = 1'b0;
          state_d   = S_IDLE;
        end else begin
          q_re    = 1'b1;
          head_d  = head_q + PW'(1);
          k_d     = 3'd0;
          state_d = S_NB;
        end
      end
      S_NB: begin
        if (nb_hit) begin
          done_d    = 1'b1;
          move_d    = (dist_inc > (DW+1)'(255)) ? 8'd255 : dist_inc[7:0];
          reached_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          pend_d      = nb_in;
          pend_addr_d = nb_addr;
          k_d         = k_q + 3'd1;
          if (k_q == 3'd7) begin
            state_d = S_LAST;
          end
        end
      end
      S_LAST: begin
        // close the level once its last square is expanded
        if (head_q == lvl_q) begin
          dist_d = dist_q + DW'(1);
          lvl_d  = tail_nxt;
        end
        state_d = S_POP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      lvl_q   <= '0;
      dist_q  <= '0;
      k_q     <= '0;
      pend_q  <= 1'b0;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      lvl_q   <= lvl_d;
      dist_q  <= dist_d;
      k_q     <= k_d;
      pend_q  <= pend_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    side_q      <= side_d;
    sx_q        <= sx_d;
    sy_q        <= sy_d;
    tx_q        <= tx_d;
    ty_q        <= ty_d;
    pend_addr_q <= pend_addr_d;
    move_q      <= move_d;
    reached_q   <= reached_d;
  end

  kmd_visited_map #(
    .AW (AW)
  ) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  kmd_frontier_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (q_re),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign busy         = (state_q != S_IDLE);
  assign done_o       = done_q;
  assign move_count_o = move_q;
  assign reached_o    = reached_q;

  // a result word always leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result word while search still running");

  // the head never passes the tail
  a_head_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("queue head passed tail");

  // a pending visited check only lives inside neighbor expansion
  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_NB || state_q == S_LAST))
    else $error("pending neighbor outside expansion");

  // the queue never holds more than one entry per square
  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= PW'(2**AW))
    else $error("frontier queue overflow");

endmodule

/* src/kmd_visited_map.sv */
// ----------------------------------------------------------------------------
// kmd_visited_map
// one bit per square, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kmd_visited_map #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/kmd_frontier_queue.sv */
// ----------------------------------------------------------------------------
// kmd_frontier_queue
// frontier square storage, written at the tail and read at the head
// ----------------------------------------------------------------------------
module kmd_frontier_queue #(
  parameter int AW = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [AW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [AW-1:0] rdata_o
);

  logic [AW-1:0] mem_q [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* dv/knight_move_distance_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// knight_move_distance_test
// self-checking bench: each query word is scored by a local breadth-first search
// ----------------------------------------------------------------------------
// A queue of query words is filled up front: first a directed set, then random
// queries. The directed set covers equal squares, empty and tiny boards,
// unreachable squares, off-board squares, sides above the largest board, and
// a few full-board searches. The random queries are mostly small boards, with
// some large boards where the target lies near the start. A clocked driver
// takes words from the queue and works the start/busy handshake. At each
// accept it scores the word with its own search and files the expected
// answer. A clocked monitor checks every done_o strobe against the oldest
// answer. The sender idles in three phases: 35 percent, then 61 percent,
// then never. At each phase change it holds off until all answers are in.
// ----------------------------------------------------------------------------
module knight_move_distance_test;

  // board geometry used by the local search
  localparam int GRID  = kmd_pkg::MAX_SIDE_DEF;
  localparam int CELLS = GRID * GRID;

  // knight hops, same order as the block walks them
  localparam int HOP_DX [8] = '{2, 2, 1, 1, -2, -2, -1, -1};
  localparam int HOP_DY [8] = '{1, -1, 2, -2, 1, -1, 2, -2};

  // one query word plus how the sender treats it
  typedef struct {
    logic [8:0] side;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] tx;
    logic [7:0] ty;
    int         idle_pct;  // chance in a hundred that the sender waits a cycle
    bit         drain;     // hold the word until every answer has come back
  } query_t;

  // one answer word
  typedef struct {
    logic [7:0] move_count;
    logic       reached;
  } answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [8:0] board_side_i = '0;
  logic [7:0] start_x_i = '0;
  logic [7:0] start_y_i = '0;
  logic [7:0] target_x_i = '0;
  logic [7:0] target_y_i = '0;
  logic       done_o;
  logic [7:0] move_count_o;
  logic       reached_o;

  query_t  query_backlog [$];
  answer_t answer_fifo [$];
  query_t  live_query;
  int      mismatch_cnt = 0;
  longint  cycle_cnt = 0;
  longint  cycle_limit = 200000;

  // scratch space for the local search
  bit seen_sq [CELLS];
  int frontier [CELLS];

  knight_move_distance i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .board_side_i (board_side_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .done_o       (done_o),
    .move_count_o (move_count_o),
    .reached_o    (reached_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // least knight moves, searched one distance level at a time
  function automatic answer_t knight_distance(query_t q);
    answer_t ans;
    int      side, tx, ty;
    int      head, tail, lvl_end, dist_now, hop_cnt;
    int      sq, cx, cy, nx, ny, k;
    bit      found;
    ans.move_count = '0;
    ans.reached    = 1'b0;
    // same square answers at once, on or off the board
    if (q.sx == q.tx && q.sy == q.ty) begin
      ans.reached = 1'b1;
      return ans;
    end
    // sides above the largest board are clipped
    side    = (int'(q.side) > GRID) ? GRID : int'(q.side);
    tx      = int'(q.tx);
    ty      = int'(q.ty);
    found   = 1'b0;
    hop_cnt = 0;
    if (int'(q.sx) < side && int'(q.sy) < side && tx < side && ty < side) begin
      foreach (seen_sq[i]) seen_sq[i] = 1'b0;
      // mark a square when it is queued, so each square is queued once
      sq = int'(q.sy) * GRID + int'(q.sx);
      seen_sq[sq] = 1'b1;
      frontier[0] = sq;
      head     = 0;
      tail     = 1;
      lvl_end  = 1;
      dist_now = 0;
      while (!found && head < tail) begin
        sq = frontier[head];
        head++;
        cx = sq % GRID;
        cy = sq / GRID;
        for (k = 0; k < 8 && !found; k++) begin
          nx = cx + HOP_DX[k];
          ny = cy + HOP_DY[k];
          if (nx >= 0 && ny >= 0 && nx < side && ny < side) begin
            if (nx == tx && ny == ty) begin
              found   = 1'b1;
              hop_cnt = dist_now + 1;
            end else if (!seen_sq[ny * GRID + nx]) begin
              seen_sq[ny * GRID + nx] = 1'b1;
              frontier[tail] = ny * GRID + nx;
              tail++;
            end
          end
        end
        // a level is done once its last square has been expanded
        if (!found && head == lvl_end) begin
          dist_now++;
          lvl_end = tail;
        end
      end
    end
    if (found) begin
      ans.move_count = (hop_cnt > 255) ? 8'd255 : 8'(hop_cnt);
      ans.reached    = 1'b1;
    end
    return ans;
  endfunction

  // queue a query word and grow the run limit by its worst-case cost
  function automatic void add_query(int side, int sx, int sy, int tx, int ty,
                                    int idle_pct, bit drain);
    query_t q;
    int     eff;
    q.side     = 9'(side);
    q.sx       = 8'(sx);
    q.sy       = 8'(sy);
    q.tx       = 8'(tx);
    q.ty       = 8'(ty);
    q.idle_pct = idle_pct;
    q.drain    = drain;
    query_backlog.push_back(q);
    eff = (side > GRID) ? GRID : side;
    // clearing pass plus a share for every board square, taken four times over, plus sender gaps
    cycle_limit += 4 * (longint'(CELLS) + 10 * longint'(eff) * eff + 64) + 400;
  endfunction

  // driver: present words from the backlog, score each one at its accept
  always @(posedge clk_i) begin
    query_t nxt;
    bit     go;
    if (rst_ni) begin
      if (start && !busy) begin
        answer_fifo.push_back(knight_distance(live_query));
      end
      // a word may change only when none is waiting on busy
      if (!start || !busy) begin
        go = 1'b0;
        if (query_backlog.size() != 0) begin
          if (query_backlog[0].drain) begin
            // nothing in flight and no strobe at this edge
            go = (answer_fifo.size() == 0) && !done_o && !(start && !busy);
          end else begin
            go = ($urandom_range(99) >= query_backlog[0].idle_pct);
          end
        end
        if (go) begin
          nxt = query_backlog.pop_front();
          live_query   <= nxt;
          start        <= 1'b1;
          board_side_i <= nxt.side;
          start_x_i    <= nxt.sx;
          start_y_i    <= nxt.sy;
          target_x_i   <= nxt.tx;
          target_y_i   <= nxt.ty;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobe is matched with the oldest expected answer
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && done_o) begin
      if (answer_fifo.size() == 0) begin
        $display("%0t: answer word with none expected: move_count %0d reached %0b",
                 $time, move_count_o, reached_o);
        mismatch_cnt++;
      end else begin
        exp_ans = answer_fifo.pop_front();
        if (move_count_o !== exp_ans.move_count) begin
          $display("%0t: move_count expected %0d actual %0d",
                   $time, exp_ans.move_count, move_count_o);
          mismatch_cnt++;
        end
        if (reached_o !== exp_ans.reached) begin
          $display("%0t: reached expected %0b actual %0b",
                   $time, exp_ans.reached, reached_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("knight_move_distance_test NOT OK");
      $finish;
    end
  end

  initial begin
    int ph, n, pct, kind, side, eff, sx, sy, tx, ty;

    // directed: equal squares on no board, the largest side, off the board
    add_query(0, 0, 0, 0, 0, 35, 1'b0);
    add_query(511, 255, 255, 255, 255, 35, 1'b0);
    add_query(4, 200, 17, 200, 17, 35, 1'b0);
    // empty board and a one-square board
    add_query(0, 0, 0, 1, 2, 35, 1'b0);
    add_query(1, 0, 0, 0, 1, 35, 1'b0);
    // tiny and small boards, some with the target out of reach
    add_query(2, 0, 0, 1, 1, 35, 1'b0);
    add_query(3, 0, 0, 1, 1, 35, 1'b0);
    add_query(3, 0, 0, 2, 2, 35, 1'b0);
    add_query(4, 0, 0, 3, 3, 35, 1'b0);
    add_query(8, 0, 0, 1, 0, 35, 1'b0);
    add_query(8, 0, 0, 7, 7, 35, 1'b0);
    // start or target just off the board, then both squares on a side-16 board
    add_query(8, 8, 3, 0, 0, 35, 1'b0);
    add_query(8, 0, 0, 2, 8, 35, 1'b0);
    add_query(16, 15, 0, 0, 15, 35, 1'b0);
    // far edge and center of the largest board, side clipped from above
    add_query(256, 255, 255, 254, 253, 35, 1'b0);
    add_query(300, 0, 0, 1, 2, 35, 1'b0);
    add_query(256, 128, 128, 127, 127, 35, 1'b0);
    // full-board searches, corner to corner
    add_query(511, 255, 0, 0, 255, 35, 1'b1);
    add_query(256, 0, 0, 255, 255, 35, 1'b0);

    // random queries in three idling phases, the second and third each opened by a drain
    for (ph = 0; ph < 3; ph++) begin
      pct = (ph == 0) ? 35 : ((ph == 1) ? 61 : 0);
      for (n = 0; n < 33 + (ph == 2); n++) begin
        kind = $urandom_range(99);
        if (kind < 15) begin
          // same square, any side
          side = $urandom_range(511);
          sx   = $urandom_range(255);
          sy   = $urandom_range(255);
          tx   = sx;
          ty   = sy;
        end else if (kind < 25) begin
          // noise: small side, coordinates anywhere
          side = $urandom_range(16);
          sx   = $urandom_range(255);
          sy   = $urandom_range(255);
          tx   = $urandom_range(255);
          ty   = $urandom_range(255);
        end else if (kind < 80) begin
          // small board, both squares on it
          side = $urandom_range(16, 1);
          sx   = $urandom_range(side - 1);
          sy   = $urandom_range(side - 1);
          tx   = $urandom_range(side - 1);
          ty   = $urandom_range(side - 1);
        end else begin
          // large board, target a few squares from the start
          side = $urandom_range(511, 17);
          eff  = (side > GRID) ? GRID : side;
          sx   = $urandom_range(eff - 1);
          sy   = $urandom_range(eff - 1);
          tx   = sx + $urandom_range(12) - 6;
          ty   = sy + $urandom_range(12) - 6;
          tx   = (tx < 0) ? 0 : ((tx > eff - 1) ? eff - 1 : tx);
          ty   = (ty < 0) ? 0 : ((ty > eff - 1) ? eff - 1 : ty);
        end
        add_query(side, sx, sy, tx, ty, pct, (n == 0) && (ph != 0));
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // all words taken and all answers back
    while (query_backlog.size() != 0 || start || answer_fifo.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (40) @(posedge clk_i);

    if (mismatch_cnt == 0 && answer_fifo.size() == 0) begin
      $display("knight_move_distance_test OK");
    end else begin
      $display("knight_move_distance_test NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/kmd_pkg.sv
src/kmd_visited_map.sv
src/kmd_frontier_queue.sv
src/knight_move_distance.sv
dv/knight_move_distance_test.sv
